// ===== rtl/ryc_pkg.sv =====
// Shared constants, coefficients and types of the RGB to YCbCr 4:2:0 converter.
`default_nettype none

package ryc_pkg;

  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 16;

  localparam int CFG_W       = 13;
  localparam int PIX_W       = 8;
  localparam int POS_W       = 12;
  localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);

  localparam int COEF_W = COEF_FRAC_BITS;
  localparam int PROD_W = COEF_FRAC_BITS + PIX_W;
  localparam int PAIR_W = COEF_FRAC_BITS + 9;
  localparam int SUM_W  = COEF_FRAC_BITS + 10;
  localparam int AVG_W  = SUM_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);
  localparam logic [CFG_W-1:0] WIDTH_LIMIT        = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT       = CFG_W'(MAX_HEIGHT);

  localparam logic [COEF_W-1:0] COEF_Y_R =
    COEF_W'(((64'd299 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] COEF_Y_G =
    COEF_W'(((64'd587 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] COEF_Y_B =
    COEF_W'(((64'd114 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] COEF_CB_R =
    COEF_W'(((64'd168736 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] COEF_CB_G =
    COEF_W'(((64'd331264 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] COEF_CR_G =
    COEF_W'(((64'd418688 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] COEF_CR_B =
    COEF_W'(((64'd81312 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);

  localparam logic [PROD_W:0]   Y_ROUND  = (PROD_W + 1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [PAIR_W-1:0] OFFSET_Q = PAIR_W'(128) << COEF_FRAC_BITS;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              pair_first;
    logic              store;
    logic              emit;
    logic              odd_row;
    logic [1:0]        avg_shift;
    logic [SLOT_W-1:0] slot;
  } pix_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ryc_front.sv =====
// Front end: raster position tracking and per-pixel classification.
`default_nettype none

module ryc_front
  import ryc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CFG_W-1:0] frame_width,
  input  wire logic [CFG_W-1:0] frame_height,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  input  wire logic             queue_full,
  output logic                  push,
  output pix_cmd_t              cmd
);

  logic [POS_W-1:0] column_count;
  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] column_count_next;
  logic [POS_W-1:0] row_count_next;

  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             wrap_col;
  logic [CFG_W-1:0] row_pre;
  logic [CFG_W-1:0] row_sel;
  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  logic [CFG_W-1:0] col_inc;
  logic [CFG_W-1:0] row_inc;
  logic             last_col;
  logic             has_next_row;
  logic             pair_done;

  always_comb begin
    priority if (frame_width == '0) begin
      w_eff = CFG_W'(1);
    end else if (frame_width > WIDTH_LIMIT) begin
      w_eff = WIDTH_LIMIT;
    end else begin
      w_eff = frame_width;
    end
    priority if (frame_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (frame_height > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height;
    end
  end

  always_comb begin
    wrap_col     = {1'b0, column_count} >= w_eff;
    col          = wrap_col ? '0 : column_count;
    row_pre      = {1'b0, row_count} + (wrap_col ? CFG_W'(1) : '0);
    row_sel      = (row_pre >= h_eff) ? '0 : row_pre;
    row          = row_sel[POS_W-1:0];
    col_inc      = {1'b0, col} + CFG_W'(1);
    row_inc      = {1'b0, row} + CFG_W'(1);
    last_col     = col_inc >= w_eff;
    has_next_row = row_inc < h_eff;
    pair_done    = col[0] | last_col;
  end

  always_comb begin
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = has_next_row ? row_inc[POS_W-1:0] : '0;
    end else begin
      column_count_next = col_inc[POS_W-1:0];
      row_count_next    = row;
    end
  end

  always_comb begin
    in_stall       = queue_full;
    push           = in_valid & ~queue_full;
    cmd.red        = red;
    cmd.green      = green;
    cmd.blue       = blue;
    cmd.column     = col;
    cmd.row        = row;
    cmd.pair_first = ~col[0];
    cmd.store      = pair_done & ~row[0] & has_next_row;
    cmd.emit       = pair_done & ~(~row[0] & has_next_row);
    cmd.odd_row    = row[0];
    cmd.avg_shift  = 2'(col[0]) + 2'(row[0]);
    cmd.slot       = SLOT_W'(col >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ryc_queue.sv =====
// Short command queue between the front end and the arithmetic back end.
`default_nettype none

module ryc_queue
  import ryc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  pix_cmd_t      push_cmd,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output pix_cmd_t      head_cmd
);

  pix_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  always_comb begin
    full       = count == (QPTR_W + 1)'(QUEUE_DEPTH);
    head_valid = count != '0;
    head_cmd   = entries[rd_ptr];
    do_pop     = pop & head_valid;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ryc_back.sv =====
// Back end: color products, chroma block sums with the row store, and result words.
`default_nettype none

module ryc_back
  import ryc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  pix_cmd_t              head_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  is_chroma,
  output logic [PIX_W-1:0]      luma,
  output logic [PIX_W-1:0]      cb,
  output logic [PIX_W-1:0]      cr,
  output logic [POS_W-1:0]      column,
  output logic [POS_W-1:0]      row,
  output logic                  last
);

  function automatic logic [PIX_W-1:0] chroma_avg(input logic [SUM_W-1:0] sum,
                                                 input logic [1:0] shift);
    logic [AVG_W-1:0] biased;
    logic [AVG_W-1:0] quot;
    biased = AVG_W'(sum) + (AVG_W'(1) << (COEF_FRAC_BITS - 1 + int'(shift)));
    quot   = biased >> (COEF_FRAC_BITS + int'(shift));
    return (quot > AVG_W'(255)) ? '1 : quot[PIX_W-1:0];
  endfunction

  logic go;

  // Stage 1: products.
  logic              s1_valid;
  pix_cmd_t          s1_cmd;
  logic [PROD_W-1:0] s1_yr, s1_yg, s1_yb;
  logic [PROD_W-1:0] s1_cbr, s1_cbg, s1_crg, s1_crb;

  // Stage 2: per-pixel luma and chroma.
  logic              s2_valid;
  pix_cmd_t          s2_cmd;
  logic [PIX_W-1:0]  s2_y;
  logic [PAIR_W-1:0] s2_pcb, s2_pcr;
  logic [PROD_W:0]   y_sum;
  logic [PROD_W:0]   y_quot;
  logic [PIX_W-1:0]  y_sat;
  logic [PAIR_W-1:0] pcb, pcr;

  // Stage 3: horizontal pair sums and row store read.
  logic              s3_valid;
  pix_cmd_t          s3_cmd;
  logic [PIX_W-1:0]  s3_y;
  logic [PAIR_W-1:0] s3_cb, s3_cr;
  logic [PAIR_W-1:0] cb_pair_sum, cr_pair_sum;
  logic [PAIR_W-1:0] cb_pair_sum_next, cr_pair_sum_next;
  logic [PAIR_W-1:0] cb_row_partial [STORE_DEPTH];
  logic [PAIR_W-1:0] cr_row_partial [STORE_DEPTH];
  logic [PAIR_W-1:0] rd_cb, rd_cr;
  logic [SUM_W-1:0]  blk_cb, blk_cr;

  // Output stage: one or two words per pixel.
  logic              o_valid;
  logic              o_phase;
  logic              o_chroma;
  logic [PIX_W-1:0]  o_y, o_cb, o_cr;
  logic [POS_W-1:0]  o_col, o_row;
  logic              out_take;

  always_comb begin
    out_take = o_valid & ~out_stall;
    go       = ~o_valid | (out_take & (o_phase | ~o_chroma));
    pop      = go & head_valid;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_cmd <= head_cmd;
      s1_yr  <= PROD_W'(head_cmd.red)   * PROD_W'(COEF_Y_R);
      s1_yg  <= PROD_W'(head_cmd.green) * PROD_W'(COEF_Y_G);
      s1_yb  <= PROD_W'(head_cmd.blue)  * PROD_W'(COEF_Y_B);
      s1_cbr <= PROD_W'(head_cmd.red)   * PROD_W'(COEF_CB_R);
      s1_cbg <= PROD_W'(head_cmd.green) * PROD_W'(COEF_CB_G);
      s1_crg <= PROD_W'(head_cmd.green) * PROD_W'(COEF_CR_G);
      s1_crb <= PROD_W'(head_cmd.blue)  * PROD_W'(COEF_CR_B);
    end
  end

  always_comb begin
    y_sum  = {1'b0, s1_yr} + {1'b0, s1_yg} + {1'b0, s1_yb} + Y_ROUND;
    y_quot = y_sum >> COEF_FRAC_BITS;
    y_sat  = (y_quot > (PROD_W + 1)'(255)) ? '1 : y_quot[PIX_W-1:0];
    pcb = OFFSET_Q + (PAIR_W'(s1_cmd.blue) << (COEF_FRAC_BITS - 1))
          - PAIR_W'(s1_cbr) - PAIR_W'(s1_cbg);
    pcr = OFFSET_Q + (PAIR_W'(s1_cmd.red) << (COEF_FRAC_BITS - 1))
          - PAIR_W'(s1_crg) - PAIR_W'(s1_crb);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s2_cmd <= s1_cmd;
      s2_y   <= y_sat;
      s2_pcb <= pcb;
      s2_pcr <= pcr;
    end
  end

  always_comb begin
    cb_pair_sum_next = s2_cmd.pair_first ? s2_pcb : cb_pair_sum + s2_pcb;
    cr_pair_sum_next = s2_cmd.pair_first ? s2_pcr : cr_pair_sum + s2_pcr;
  end

  always_ff @(posedge clk) begin
    if (go && s2_valid && s2_cmd.store) begin
      cb_row_partial[s2_cmd.slot] <= cb_pair_sum_next;
      cr_row_partial[s2_cmd.slot] <= cr_pair_sum_next;
    end
    if (go) begin
      rd_cb <= cb_row_partial[s2_cmd.slot];
      rd_cr <= cr_row_partial[s2_cmd.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cb_pair_sum <= '0;
      cr_pair_sum <= '0;
    end else if (go && s2_valid) begin
      cb_pair_sum <= cb_pair_sum_next;
      cr_pair_sum <= cr_pair_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s3_cmd <= s2_cmd;
      s3_y   <= s2_y;
      s3_cb  <= cb_pair_sum_next;
      s3_cr  <= cr_pair_sum_next;
    end
  end

  always_comb begin
    blk_cb = SUM_W'(s3_cb) + (s3_cmd.odd_row ? SUM_W'(rd_cb) : '0);
    blk_cr = SUM_W'(s3_cr) + (s3_cmd.odd_row ? SUM_W'(rd_cr) : '0);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      o_chroma <= s3_cmd.emit;
      o_y      <= s3_y;
      o_cb     <= chroma_avg(blk_cb, s3_cmd.avg_shift);
      o_cr     <= chroma_avg(blk_cr, s3_cmd.avg_shift);
      o_col    <= s3_cmd.column;
      o_row    <= s3_cmd.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
      o_phase  <= 1'b0;
    end else if (go) begin
      s1_valid <= head_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      o_valid  <= s3_valid;
      o_phase  <= 1'b0;
    end else if (out_take) begin
      o_phase <= 1'b1;
    end
  end

  always_comb begin
    out_valid = o_valid;
    is_chroma = o_phase;
    luma      = o_phase ? '0 : o_y;
    cb        = o_phase ? o_cb : '0;
    cr        = o_phase ? o_cr : '0;
    column    = o_phase ? (o_col >> 1) : o_col;
    row       = o_phase ? (o_row >> 1) : o_row;
    last      = o_phase | ~o_chroma;
  end

endmodule

`default_nettype wire

// ===== rtl/rgb_to_ycbcr420_converter.sv =====
// Top level of the RGB to BT.601 full-range YCbCr 4:2:0 converter.
// A pixel's luma word passes the queue, the stage 1, 2 and 3 registers and the output stage.
// Throughput: one pixel per cycle while out_stall is low; a pixel that closes a chroma block
// holds the output for two words, so an odd or lone bottom row can fill the 4-entry queue.
// Reset: synchronous; clears position, pipeline and queue state and loads 640 x 480.
// The row store is not cleared; every entry is written in an even row before it is read.
`default_nettype none

module rgb_to_ycbcr420_converter
  import ryc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     red,
  input  wire logic [PIX_W-1:0]     green,
  input  wire logic [PIX_W-1:0]     blue,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      is_chroma,
  output logic [PIX_W-1:0]          luma,
  output logic [PIX_W-1:0]          cb,
  output logic [PIX_W-1:0]          cr,
  output logic [POS_W-1:0]          column,
  output logic [POS_W-1:0]          row,
  output logic                      last
);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic     push;
  pix_cmd_t push_cmd;
  logic     queue_full;
  logic     pop;
  logic     head_valid;
  pix_cmd_t head_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  ryc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .queue_full   (queue_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  ryc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ryc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_chroma  (is_chroma),
    .luma       (luma),
    .cb         (cb),
    .cr         (cr),
    .column     (column),
    .row        (row),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== rtl/ryc_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`default_nettype none

module ryc_checker
  import ryc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             is_chroma,
  input wire logic [PIX_W-1:0] luma,
  input wire logic [PIX_W-1:0] cb,
  input wire logic [PIX_W-1:0] cr,
  input wire logic             last
);

  // A chroma word always closes the words of its pixel.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_chroma |-> last)
    else $error("Chroma word without last.");

  // Unused fields of each word kind are zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_chroma ? luma == '0 : (cb == '0 && cr == '0)))
    else $error("Unused output field is not zero.");

  // A luma word that is not last is followed at once by its chroma word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !is_chroma && !last |=> out_valid && is_chroma)
    else $error("Chroma word missing after luma word.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_chroma) && $stable(luma)
                               && $stable(cb) && $stable(cr) && $stable(last))
    else $error("Stalled output word changed.");

endmodule

bind rgb_to_ycbcr420_converter ryc_checker u_ryc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .is_chroma (is_chroma),
  .luma      (luma),
  .cb        (cb),
  .cr        (cr),
  .last      (last)
);

`default_nettype wire

// ===== sim/tb_rgb_to_ycbcr420_converter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the RGB to YCbCr 4:2:0 converter with random flow control.

module tb_rgb_to_ycbcr420_converter;
  import ryc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PIXELS = 1200;

  localparam longint unsigned Q_ONE    = 64'd1 << COEF_FRAC_BITS;
  localparam longint unsigned Q_HALF   = Q_ONE >> 1;
  localparam longint unsigned Q_OFFSET = 64'd128 << COEF_FRAC_BITS;
  localparam longint unsigned KY_R  = ((64'd299 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
  localparam longint unsigned KY_G  = ((64'd587 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
  localparam longint unsigned KY_B  = ((64'd114 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
  localparam longint unsigned KCB_R =
    ((64'd168736 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned KCB_G =
    ((64'd331264 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned KCR_G =
    ((64'd418688 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned KCR_B =
    ((64'd81312 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic             is_chroma;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             last;
  } ycc_word_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  cfg_reg_t         cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] red       = '0;
  logic [PIX_W-1:0] green     = '0;
  logic [PIX_W-1:0] blue      = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             is_chroma;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] cb;
  logic [PIX_W-1:0] cr;
  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;
  logic             last;

  pixel_t    pending_pixels[$];
  ycc_word_t expected_words[$];

  logic [CFG_W-1:0] frame_w = FRAME_WIDTH_RESET;
  logic [CFG_W-1:0] frame_h = FRAME_HEIGHT_RESET;
  int unsigned      pos_col = 0;
  int unsigned      pos_row = 0;
  longint unsigned  cb_pair = 0;
  longint unsigned  cr_pair = 0;
  longint unsigned  cb_partial [STORE_DEPTH];
  longint unsigned  cr_partial [STORE_DEPTH];

  int n_queued    = 0;
  int n_accepted  = 0;
  int n_random    = 0;
  int n_settings  = 0;
  int n_luma      = 0;
  int n_chroma    = 0;
  int n_errors    = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  int burst_left  = 0;
  int stall_seg   = 0;
  int stall_mode  = 0;
  pixel_t    drive_px;
  ycc_word_t got_word;
  ycc_word_t want_word;

  rgb_to_ycbcr420_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_chroma (is_chroma),
    .luma      (luma),
    .cb        (cb),
    .cr        (cr),
    .column    (column),
    .row       (row),
    .last      (last)
  );

  always #5 clk = ~clk;

  function automatic logic [PIX_W-1:0] avg_chroma(longint unsigned s, longint unsigned n);
    longint unsigned q;
    q = (s + n * Q_HALF) / (n * Q_ONE);
    return (q > 255) ? 8'd255 : q[PIX_W-1:0];
  endfunction

  function automatic void push_word(logic chroma, logic [PIX_W-1:0] y_v, logic [PIX_W-1:0] cb_v,
                                    logic [PIX_W-1:0] cr_v, int unsigned col_v,
                                    int unsigned row_v, logic last_v);
    ycc_word_t wd;
    wd.is_chroma = chroma;
    wd.luma      = y_v;
    wd.cb        = cb_v;
    wd.cr        = cr_v;
    wd.column    = col_v[POS_W-1:0];
    wd.row       = row_v[POS_W-1:0];
    wd.last      = last_v;
    expected_words.push_back(wd);
  endfunction

  function automatic void predict_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                        logic [PIX_W-1:0] b);
    int unsigned     w;
    int unsigned     h;
    int unsigned     col;
    int unsigned     rw;
    int unsigned     slot;
    longint unsigned y;
    longint unsigned pcb;
    longint unsigned pcr;
    longint unsigned scb;
    longint unsigned scr;
    longint unsigned n;
    bit              odd_col;
    bit              pair_done;
    w = (frame_w == 0) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w);
    h = (frame_h == 0) ? 1 : ((frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h);
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    col = pos_col;
    rw  = pos_row;

    y = (KY_R * r + KY_G * g + KY_B * b + Q_HALF) >> COEF_FRAC_BITS;
    if (y > 255) y = 255;
    pcb = Q_OFFSET + Q_HALF * b - KCB_R * r - KCB_G * g;
    pcr = Q_OFFSET + Q_HALF * r - KCR_G * g - KCR_B * b;

    odd_col = (col & 1) != 0;
    if (!odd_col) begin
      cb_pair = pcb;
      cr_pair = pcr;
    end else begin
      cb_pair += pcb;
      cr_pair += pcr;
    end
    pair_done = odd_col || (col + 1 >= w);
    n = odd_col ? 2 : 1;
    slot = (col >> 1) % STORE_DEPTH;

    pos_col = col + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = rw + 1;
      if (pos_row >= h) pos_row = 0;
    end

    if (pair_done && !((rw & 1) == 0 && rw + 1 < h)) begin
      scb = cb_pair;
      scr = cr_pair;
      if ((rw & 1) != 0) begin
        scb += cb_partial[slot];
        scr += cr_partial[slot];
        n = n * 2;
      end
      push_word(1'b0, y[PIX_W-1:0], '0, '0, col, rw, 1'b0);
      push_word(1'b1, '0, avg_chroma(scb, n), avg_chroma(scr, n), col >> 1, rw >> 1, 1'b1);
    end else begin
      if (pair_done) begin
        cb_partial[slot] = cb_pair;
        cr_partial[slot] = cr_pair;
      end
      push_word(1'b0, y[PIX_W-1:0], '0, '0, col, rw, 1'b1);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want_v, got_v);
      n_errors++;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_component();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int eff_dim(int v);
    return (v == 0) ? 1 : ((v > 4096) ? 4096 : v);
  endfunction

  task automatic add_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    pending_pixels.push_back(p);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expected_words.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w = CFG_W'(value);
    else frame_h = CFG_W'(value);
  endtask

  // Settings change only between whole frames, so odd rows always find their partial sums.
  task automatic apply_setting(int wv, int hv);
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_FRAME_WIDTH, wv);
      write_reg(REG_FRAME_HEIGHT, hv);
    end else begin
      write_reg(REG_FRAME_HEIGHT, hv);
      write_reg(REG_FRAME_WIDTH, wv);
    end
    n_settings++;
    @(negedge clk);
  endtask

  task automatic queue_random_frames(int wv, int hv, int frames);
    int count;
    count = eff_dim(wv) * eff_dim(hv) * frames;
    for (int i = 0; i < count; i++) add_pixel(rand_component(), rand_component(),
                                              rand_component());
    n_random += count;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pixel(red, green, blue);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          drive_px = pending_pixels.pop_front();
          in_valid <= 1'b1;
          red      <= drive_px.red;
          green    <= drive_px.green;
          blue     <= drive_px.blue;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(0, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_seg == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_seg  = $urandom_range(1, 50);
      end
      stall_seg--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ((stall_seg % 8) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_word = {is_chroma, luma, cb, cr, column, row, last};
      if (got_word.is_chroma) n_chroma++;
      else n_luma++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, got_word);
        n_errors++;
      end else begin
        want_word = expected_words.pop_front();
        check_field("is_chroma", want_word.is_chroma, got_word.is_chroma);
        check_field("luma", want_word.luma, got_word.luma);
        check_field("cb", want_word.cb, got_word.cb);
        check_field("cr", want_word.cr, got_word.cr);
        check_field("column", want_word.column, got_word.column);
        check_field("row", want_word.row, got_word.row);
        check_field("last", want_word.last, got_word.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.", cycle_count,
               expected_words.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int wv;
    int hv;
    int frames;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Odd width and height: clipped blocks on the right column and the bottom row.
    apply_setting(3, 3);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd255);
    add_pixel(8'd128, 8'd128, 8'd128);

    // Zero width and height act as a single pixel frame.
    apply_setting(0, 0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);

    apply_setting(2, 2);
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);

    apply_setting(1, 2);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd255);

    while (n_random < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: wv = 0;
        1: wv = 1;
        2: wv = 2;
        3, 4, 5, 6: wv = $urandom_range(3, 16);
        7, 8: wv = $urandom_range(17, 80);
        default: wv = $urandom_range(81, 200);
      endcase
      case ($urandom_range(0, 5))
        0: hv = 0;
        1: hv = 1;
        default: hv = $urandom_range(2, 7);
      endcase
      frames = (eff_dim(wv) * eff_dim(hv) > 200) ? 1 : $urandom_range(1, 3);
      if (n_random + eff_dim(wv) * eff_dim(hv) * frames <= RANDOM_PIXELS + 50) begin
        apply_setting(wv, hv);
        queue_random_frames(wv, hv, frames);
      end
    end

    apply_setting(5, 3);
    queue_random_frames(5, 3, 2);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Streamed %0d pixels under %0d frame settings, from 1x1 up to 200 wide and 7 tall.",
             n_queued, n_settings);
    $display("Checked %0d luma and %0d chroma words; %0d mismatches.", n_luma, n_chroma,
             n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ryc_pkg.sv
rtl/ryc_front.sv
rtl/ryc_queue.sv
rtl/ryc_back.sv
rtl/rgb_to_ycbcr420_converter.sv
rtl/ryc_checker.sv
sim/tb_rgb_to_ycbcr420_converter.sv
